// File: sv/fbh_pkg.sv
`default_nettype none

package fbh_pkg;

  localparam int unsigned HASH_W = 32;
  localparam int unsigned BYTE_W = 8;

  localparam logic [HASH_W-1:0] FNV_OFFSET_BASIS = 32'h811c_9dc5;
  localparam logic [HASH_W-1:0] FNV_PRIME        = 32'h0100_0193;
  localparam logic [HASH_W-1:0] TABLE_SIZE_RESET = 32'h0001_0000;

  // Steps of the restoring divider: one quotient bit per step.
  localparam int unsigned DIV_STEPS = HASH_W;
  localparam int unsigned CNT_W     = $clog2(DIV_STEPS);

endpackage

`default_nettype wire

// File: sv/fnv1a_bucket_hash.sv
`default_nettype none

// FNV-1a bucket hash. Key bytes arrive one per request on the in_ channel; a
// request with in_key_end set closes the key and produces one result on the
// out_ channel: the 32-bit FNV-1a hash and that hash modulo the table size
// written through cfg_we/cfg_data (reset 65536; a table size of zero gives
// the hash itself as the bucket). A byte request that does not end a key
// is finished in the accept cycle: the XOR and the multiply by the FNV prime
// happen there. A key-end request keeps the block busy until the result is
// loaded: the hash is taken in the accept cycle, the remainder follows from a
// single shared compare-and-subtract unit that produces one bit per cycle,
// and the output register is loaded once it is free. The output register
// holds a finished result while byte requests of the next key stream in; a
// second key end waits only until the earlier result has been taken.
module fnv1a_bucket_hash
  import fbh_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  // Configuration: table size.
  input  wire logic              cfg_we,
  input  wire logic [HASH_W-1:0] cfg_data,
  // Input channel.
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic [BYTE_W-1:0] in_char_code,
  input  wire logic              in_char_present,
  input  wire logic              in_key_end,
  // Result channel.
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic [HASH_W-1:0]      out_bucket,
  output logic [HASH_W-1:0]      out_hash_value
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_DIV,
    S_LOAD
  } state_t;

  state_t            state_r;
  logic [HASH_W-1:0] table_size_r;
  logic [HASH_W-1:0] running_hash_r;
  logic [HASH_W-1:0] key_hash_r;
  logic [HASH_W-1:0] dvd_r;
  logic [HASH_W-1:0] rem_r;
  logic [CNT_W-1:0]  cnt_r;
  logic              out_valid_r;
  logic [HASH_W-1:0] out_bucket_r;
  logic [HASH_W-1:0] out_hash_value_r;

  logic              in_fire;
  logic [HASH_W-1:0] hash_nxt;
  logic [HASH_W:0]   rem_shift;
  logic [HASH_W:0]   divisor_ext;
  logic              rem_ge;
  logic [HASH_W-1:0] rem_nxt;
  logic              out_free;
  logic              publish;

  assign in_ready = (state_r == S_IDLE);
  assign in_fire  = in_valid && in_ready;
  assign out_free = !out_valid_r || out_ready;
  assign publish  = (state_r == S_LOAD) && out_free;

  // Hash update for the request in hand; the multiply is by a constant.
  always_comb begin
    if (in_char_present) begin
      hash_nxt = (running_hash_r ^ {{(HASH_W-BYTE_W){1'b0}}, in_char_code}) * FNV_PRIME;
    end else begin
      hash_nxt = running_hash_r;
    end
  end

  // Shared divider step: shift in the next dividend bit, subtract if it fits.
  assign rem_shift   = {rem_r, dvd_r[HASH_W-1]};
  assign divisor_ext = {1'b0, table_size_r};
  assign rem_ge      = (rem_shift >= divisor_ext);
  assign rem_nxt     = rem_ge ? HASH_W'(rem_shift - divisor_ext) : rem_shift[HASH_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= S_IDLE;
      table_size_r   <= TABLE_SIZE_RESET;
      running_hash_r <= FNV_OFFSET_BASIS;
      out_valid_r    <= 1'b0;
      cnt_r          <= '0;
    end else begin
      if (cfg_we) begin
        table_size_r <= cfg_data;
      end
      // A new result replaces the old one in the same cycle it is taken.
      if (publish) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_fire) begin
            if (in_key_end) begin
              // Close the key: keep the hash and start the remainder.
              running_hash_r <= FNV_OFFSET_BASIS;
              key_hash_r     <= hash_nxt;
              dvd_r          <= hash_nxt;
              rem_r          <= '0;
              cnt_r          <= CNT_W'(DIV_STEPS - 1);
              state_r        <= S_DIV;
            end else begin
              running_hash_r <= hash_nxt;
            end
          end
        end
        S_DIV: begin
          rem_r <= rem_nxt;
          dvd_r <= {dvd_r[HASH_W-2:0], 1'b0};
          cnt_r <= cnt_r - 1'b1;
          if (cnt_r == '0) begin
            state_r <= S_LOAD;
          end
        end
        S_LOAD: begin
          // Wait for the output register to be free, then publish.
          if (out_free) begin
            out_hash_value_r <= key_hash_r;
            out_bucket_r     <= (table_size_r != '0) ? rem_r : key_hash_r;
            state_r          <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid      = out_valid_r;
  assign out_bucket     = out_bucket_r;
  assign out_hash_value = out_hash_value_r;

`ifndef SYNTH
  // A key end always starts the divider and drops ready.
  a_key_end_divides: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_key_end |=> state_r == S_DIV && !in_ready)
    else $error("key end did not start the divider");

  // The running hash is back at the offset basis while a remainder is in work.
  a_hash_restarted: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_DIV |-> running_hash_r == FNV_OFFSET_BASIS)
    else $error("running hash not restarted at key end");

  // A finished result is published as soon as the output register is free.
  a_load_publishes: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_LOAD && (!out_valid || out_ready) |=> out_valid && state_r == S_IDLE)
    else $error("finished result not published");
`endif

endmodule

`default_nettype wire
